// ----- sv/y2r_pkg.sv -----
// ----------------------------------------------------------------------------
// y2r_pkg
// Types, coefficients and the channel clamp shared by the YUV411 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int FRAC_BITS = 20;
    localparam int PROD_W    = 30;
    localparam int OFF_W     = 11;

    localparam logic signed [21:0] COEF_RV = 22'sd1437288;
    localparam logic signed [21:0] COEF_GV = 22'sd731907;
    localparam logic signed [21:0] COEF_GU = 22'sd354034;
    localparam logic signed [21:0] COEF_BU = 22'sd1816601;

    typedef struct packed {
        logic [7:0] u;
        logic [7:0] y_a;
        logic [7:0] y_b;
        logic [7:0] v;
        logic [7:0] y_c;
        logic [7:0] y_d;
    } y2r_in_t;

    typedef struct packed {
        logic [7:0] red_a;
        logic [7:0] green_a;
        logic [7:0] blue_a;
        logic [7:0] red_b;
        logic [7:0] green_b;
        logic [7:0] blue_b;
        logic [7:0] red_c;
        logic [7:0] green_c;
        logic [7:0] blue_c;
        logic [7:0] red_d;
        logic [7:0] green_d;
        logic [7:0] blue_d;
    } y2r_out_t;

    typedef struct packed {
        logic [7:0] y_a;
        logic [7:0] y_b;
        logic [7:0] y_c;
        logic [7:0] y_d;
    } y2r_luma_t;

    // Integer parts of the chroma terms, floored, plus the luma that goes with them.
    typedef struct packed {
        logic signed [OFF_W-1:0] r_off;
        logic signed [OFF_W-1:0] g_off;
        logic signed [OFF_W-1:0] b_off;
        y2r_luma_t               luma;
    } y2r_chroma_t;

    // Luma is an exact integer, so flooring the sum equals luma plus the floored offset.
    function automatic logic [7:0] clamp_channel(input logic [7:0] luma,
                                                 input logic signed [OFF_W-1:0] off);
        logic signed [OFF_W:0] sum;
        logic [7:0]            res;
        sum = signed'({{(OFF_W-7){1'b0}}, luma}) + signed'({off[OFF_W-1], off});
        if (sum[OFF_W])
        begin
            res = 8'd0;
        end
        else if (sum[OFF_W-1:8] != '0)
        begin
            res = 8'd255;
        end
        else
        begin
            res = sum[7:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/y2r_in_if.sv -----
// ----------------------------------------------------------------------------
// y2r_in_if
// Valid/ready channel that carries one packed UYYVYY group per word.
// ----------------------------------------------------------------------------
interface y2r_in_if
    import y2r_pkg::*;
();
    logic    valid;
    logic    ready;
    y2r_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/y2r_out_if.sv -----
// ----------------------------------------------------------------------------
// y2r_out_if
// Valid/ready channel that carries four RGB24 pixels per word.
// ----------------------------------------------------------------------------
interface y2r_out_if
    import y2r_pkg::*;
();
    logic     valid;
    logic     ready;
    y2r_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/yuv411_to_rgb24_converter_core.sv -----
// ----------------------------------------------------------------------------
// yuv411_to_rgb24_converter_core
// Converts one UYYVYY group per word into four clamped RGB24 pixels.
// ----------------------------------------------------------------------------
// An accepted input word passes through the chroma product, offset and pixel registers to the output word.
// Throughput is one word per cycle while the output word is not held; the three stages advance together.
// When the output word is held, the stages stall and the input is not ready.
// Reset clears the valid bits of all stages; the data registers keep their value.
module yuv411_to_rgb24_converter_core
    import y2r_pkg::*;
(
    input logic clk,
    input logic rst_n,
    y2r_in_if.sink    yuv,
    y2r_out_if.source rgb
);

    logic        en;
    logic        chr_valid;
    y2r_chroma_t chr_data;
    logic        out_valid_reg;
    y2r_out_t    out_data;

    assign en        = !out_valid_reg || rgb.ready;
    assign yuv.ready = en;

    y2r_chroma u_chroma (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (yuv.valid),
        .in_data   (yuv.data),
        .out_valid (chr_valid),
        .out_data  (chr_data)
    );

    y2r_pixel u_pixel_a (
        .clk   (clk),
        .en    (en),
        .luma  (chr_data.luma.y_a),
        .r_off (chr_data.r_off),
        .g_off (chr_data.g_off),
        .b_off (chr_data.b_off),
        .red   (out_data.red_a),
        .green (out_data.green_a),
        .blue  (out_data.blue_a)
    );

    y2r_pixel u_pixel_b (
        .clk   (clk),
        .en    (en),
        .luma  (chr_data.luma.y_b),
        .r_off (chr_data.r_off),
        .g_off (chr_data.g_off),
        .b_off (chr_data.b_off),
        .red   (out_data.red_b),
        .green (out_data.green_b),
        .blue  (out_data.blue_b)
    );

    y2r_pixel u_pixel_c (
        .clk   (clk),
        .en    (en),
        .luma  (chr_data.luma.y_c),
        .r_off (chr_data.r_off),
        .g_off (chr_data.g_off),
        .b_off (chr_data.b_off),
        .red   (out_data.red_c),
        .green (out_data.green_c),
        .blue  (out_data.blue_c)
    );

    y2r_pixel u_pixel_d (
        .clk   (clk),
        .en    (en),
        .luma  (chr_data.luma.y_d),
        .r_off (chr_data.r_off),
        .g_off (chr_data.g_off),
        .b_off (chr_data.b_off),
        .red   (out_data.red_d),
        .green (out_data.green_d),
        .blue  (out_data.blue_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chr_valid;
        end
    end

    assign rgb.valid = out_valid_reg;
    assign rgb.data  = out_data;

endmodule

// ----- sv/y2r_chroma.sv -----
// ----------------------------------------------------------------------------
// y2r_chroma
// Two stages: chroma products, then the floored red, green and blue offsets.
// ----------------------------------------------------------------------------
module y2r_chroma
    import y2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  y2r_in_t     in_data,
    output logic        out_valid,
    output y2r_chroma_t out_data
);

    logic signed [7:0]        cu;
    logic signed [7:0]        cv;
    logic signed [PROD_W-1:0] p_rv_next;
    logic signed [PROD_W-1:0] p_gv_next;
    logic signed [PROD_W-1:0] p_gu_next;
    logic signed [PROD_W-1:0] p_bu_next;
    logic signed [PROD_W-1:0] p_rv_reg;
    logic signed [PROD_W-1:0] p_gv_reg;
    logic signed [PROD_W-1:0] p_gu_reg;
    logic signed [PROD_W-1:0] p_bu_reg;
    y2r_luma_t                luma_reg;
    logic                     s1_valid_reg;
    logic signed [PROD_W:0]   g_sum;
    y2r_chroma_t              out_data_next;
    y2r_chroma_t              out_data_reg;
    logic                     out_valid_reg;

    // Subtracting 128 from a byte only flips its top bit.
    assign cu = signed'({~in_data.u[7], in_data.u[6:0]});
    assign cv = signed'({~in_data.v[7], in_data.v[6:0]});

    always_comb
    begin
        p_rv_next = PROD_W'(COEF_RV) * PROD_W'(cv);
        p_gv_next = PROD_W'(COEF_GV) * PROD_W'(cv);
        p_gu_next = PROD_W'(COEF_GU) * PROD_W'(cu);
        p_bu_next = PROD_W'(COEF_BU) * PROD_W'(cu);
    end

    always_comb
    begin
        g_sum = -(signed'({p_gv_reg[PROD_W-1], p_gv_reg})
                + signed'({p_gu_reg[PROD_W-1], p_gu_reg}));
        out_data_next.r_off = signed'({p_rv_reg[PROD_W-1], p_rv_reg[PROD_W-1:FRAC_BITS]});
        out_data_next.g_off = g_sum[PROD_W:FRAC_BITS];
        out_data_next.b_off = signed'({p_bu_reg[PROD_W-1], p_bu_reg[PROD_W-1:FRAC_BITS]});
        out_data_next.luma  = luma_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rv_reg       <= p_rv_next;
            p_gv_reg       <= p_gv_next;
            p_gu_reg       <= p_gu_next;
            p_bu_reg       <= p_bu_next;
            luma_reg.y_a   <= in_data.y_a;
            luma_reg.y_b   <= in_data.y_b;
            luma_reg.y_c   <= in_data.y_c;
            luma_reg.y_d   <= in_data.y_d;
            out_data_reg   <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/y2r_pixel.sv -----
// ----------------------------------------------------------------------------
// y2r_pixel
// Adds the chroma offsets to one luma sample and clamps each channel.
// ----------------------------------------------------------------------------
module y2r_pixel
    import y2r_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [7:0]              luma,
    input  logic signed [OFF_W-1:0] r_off,
    input  logic signed [OFF_W-1:0] g_off,
    input  logic signed [OFF_W-1:0] b_off,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue
);

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= clamp_channel(luma, r_off);
            green_reg <= clamp_channel(luma, g_off);
            blue_reg  <= clamp_channel(luma, b_off);
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ----- sv/y2r_checker.sv -----
// ----------------------------------------------------------------------------
// y2r_checker
// Port-level checks on stalling, flow control and latency of the converter.
// ----------------------------------------------------------------------------
module y2r_checker
    import y2r_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input y2r_out_t out_data
);

    a_hold_stalled_word : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output word changed while stalled.");

    a_drop_only_when_taken : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("Output word vanished without being taken.");

    a_ready_follows_output : assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("Input ready does not follow the output stage.");

    a_latency_three : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("Accepted word did not appear after three cycles.");

endmodule

bind yuv411_to_rgb24_converter_core y2r_checker u_y2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yuv.valid),
    .in_ready  (yuv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (rgb.data)
);

// ----- tb/tb_yuv411_to_rgb24_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv411_to_rgb24_converter_core
// Drives UYYVYY groups into the converter with random gaps and output stalls,
// predicts the four RGB24 pixels of every accepted group in fixed point, and
// compares every output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_yuv411_to_rgb24_converter_core;
    import y2r_pkg::*;

    localparam int RANDOM_GROUPS = 1800;
    localparam int IDLE_PERCENT  = 19;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 50;

    class rgb_scoreboard;
        localparam longint RV_SCALED = 1437288;
        localparam longint GV_SCALED = 731907;
        localparam longint GU_SCALED = 354034;
        localparam longint BU_SCALED = 1816601;
        localparam int     SHIFT     = 20;

        y2r_out_t    pending_pixels[$];
        int unsigned mismatches;
        string       field_name[12] = '{"red_a", "green_a", "blue_a", "red_b", "green_b",
                                        "blue_b", "red_c", "green_c", "blue_c", "red_d",
                                        "green_d", "blue_d"};

        function logic [7:0] floor_clamp(longint acc);
            longint whole;
            whole = acc >>> SHIFT;
            if (whole < 0)
            begin
                return 8'd0;
            end
            if (whole > 255)
            begin
                return 8'd255;
            end
            return whole[7:0];
        endfunction

        function y2r_out_t convert_group(y2r_in_t grp);
            longint     cu;
            longint     cv;
            longint     ys;
            logic [7:0] luma[4];
            y2r_out_t   pix;
            cu = longint'(grp.u) - 128;
            cv = longint'(grp.v) - 128;
            luma[0] = grp.y_a;
            luma[1] = grp.y_b;
            luma[2] = grp.y_c;
            luma[3] = grp.y_d;
            for (int k = 0; k < 4; k++)
            begin
                ys = longint'(luma[k]) << SHIFT;
                pix[95-24*k -: 8] = floor_clamp(ys + RV_SCALED * cv);
                pix[87-24*k -: 8] = floor_clamp(ys - GV_SCALED * cv - GU_SCALED * cu);
                pix[79-24*k -: 8] = floor_clamp(ys + BU_SCALED * cu);
            end
            return pix;
        endfunction

        function void note_group(y2r_in_t grp);
            pending_pixels.push_back(convert_group(grp));
        endfunction

        function bit drained();
            return pending_pixels.size() == 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
            begin
                $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            end
        endtask

        task check_pixels(y2r_out_t got);
            y2r_out_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("word with no group pending", got[7:0], 0);
                return;
            end
            want = pending_pixels.pop_front();
            for (int i = 0; i < 12; i++)
            begin
                if (got[95-8*i -: 8] !== want[95-8*i -: 8])
                begin
                    report_mismatch(field_name[i], got[95-8*i -: 8], want[95-8*i -: 8]);
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    bit   hold_output;
    int   cycle_count;

    y2r_in_if  yuv ();
    y2r_out_if rgb ();

    rgb_scoreboard pixel_board = new();

    yuv411_to_rgb24_converter_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .yuv   (yuv.sink),
        .rgb   (rgb.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rgb.valid && rgb.ready)
        begin
            pixel_board.check_pixels(rgb.data);
        end
    end

    initial
    begin
        rgb.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                rgb.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rgb.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    task send_group(y2r_in_t grp);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            yuv.valid <= 1'b0;
            @(posedge clk);
        end
        yuv.valid <= 1'b1;
        yuv.data  <= grp;
        do
        begin
            @(posedge clk);
        end
        while (!yuv.ready);
        pixel_board.note_group(grp);
    endtask

    task wait_drained();
        yuv.valid <= 1'b0;
        @(posedge clk);
        while (!pixel_board.drained())
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        y2r_in_t directed[$];
        y2r_in_t grp;

        rst_n       = 1'b0;
        steady      = 1'b0;
        hold_output = 1'b0;
        yuv.valid   = 1'b0;
        yuv.data    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of chroma and luma, neutral chroma, and groups that drive
        // channels below zero or above full scale.
        directed = '{
            y2r_in_t'({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}),
            y2r_in_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}),
            y2r_in_t'({8'h80, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE}),
            y2r_in_t'({8'h00, 8'h00, 8'h40, 8'h00, 8'hC0, 8'hFF}),
            y2r_in_t'({8'hFF, 8'h00, 8'h40, 8'hFF, 8'hC0, 8'hFF}),
            y2r_in_t'({8'h00, 8'h10, 8'h80, 8'hFF, 8'hF0, 8'hFF}),
            y2r_in_t'({8'hFF, 8'h00, 8'h80, 8'h00, 8'hF0, 8'hFF}),
            y2r_in_t'({8'h80, 8'h00, 8'h80, 8'hFF, 8'hF0, 8'hFF}),
            y2r_in_t'({8'h80, 8'h00, 8'h80, 8'h00, 8'hF0, 8'hFF}),
            y2r_in_t'({8'h00, 8'h00, 8'h80, 8'h80, 8'hF0, 8'hFF}),
            y2r_in_t'({8'hFF, 8'h00, 8'h80, 8'h80, 8'hF0, 8'hFF}),
            y2r_in_t'({8'h7F, 8'h55, 8'hAA, 8'h81, 8'h0F, 8'hF0}),
            y2r_in_t'({8'h81, 8'hAA, 8'h55, 8'h7F, 8'hF0, 8'h0F}),
            y2r_in_t'({8'h01, 8'h7F, 8'h80, 8'hFE, 8'h01, 8'hFE})
        };
        foreach (directed[i])
        begin
            send_group(directed[i]);
        end

        for (int n = 0; n < RANDOM_GROUPS; n++)
        begin
            if (n == 500)
            begin
                steady = 1'b1;
            end
            if (n == 900)
            begin
                steady = 1'b0;
            end
            if (n == 1200)
            begin
                hold_output = 1'b1;
            end
            if (n == 1500)
            begin
                wait_drained();
            end
            grp = y2r_in_t'({$urandom(), 16'($urandom())});
            // Some groups keep luma near the rails so the clamps are hit often.
            if ($urandom_range(0, 3) == 0)
            begin
                grp.y_a = 8'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                  : $urandom_range(240, 255));
                grp.y_d = 8'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                  : $urandom_range(240, 255));
            end
            send_group(grp);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!pixel_board.drained())
        begin
            pixel_board.report_mismatch("words never produced", 0,
                                        pixel_board.pending_pixels.size());
        end
        if (pixel_board.mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
